>>> src/qau_pkg.sv
// Shared types, constants and sum-of-products recipes for the quaternion arithmetic unit.
// No dependencies; used by qau_sop and quaternion_arithmetic_unit.
package qau_pkg;

  // Default value format: Q2.14
  localparam int VALUE_WIDTH_DEF   = 16;
  localparam int FRACTION_BITS_DEF = 14;

  // Quaternion components and result lanes
  localparam int QLEN  = 4;
  localparam int LANES = 9;
  localparam int TERMS = 4;

  typedef enum logic [1:0] {
    ACT_MUL  = 2'd0,
    ACT_ROT  = 2'd1,
    ACT_MAT  = 2'd2,
    ACT_CONJ = 2'd3
  } action_e;

  // Recipe selector for the sum-of-products pipeline
  typedef enum logic [1:0] {
    MODE_QPROD  = 2'd0,
    MODE_QVEC   = 2'd1,
    MODE_MATRIX = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    SG_ZERO  = 2'd0,
    SG_PLUS  = 2'd1,
    SG_MINUS = 2'd2
  } sign_e;

  // One term: sign * left[li] * right[ri]
  typedef struct packed {
    logic [1:0] li;
    logic [1:0] ri;
    sign_e      sg;
  } term_t;

  // One lane: sum of terms, optionally doubled, optionally taken from one
  typedef struct packed {
    term_t [TERMS-1:0] t;
    logic              dbl;
    logic              from_one;
  } lane_t;

  typedef lane_t [LANES-1:0] recipe_t;

  function automatic term_t tm(logic [1:0] li, logic [1:0] ri, sign_e sg);
    term_t r;
    r.li = li;
    r.ri = ri;
    r.sg = sg;
    return r;
  endfunction

  function automatic lane_t mk_lane(term_t t0, term_t t1, term_t t2, term_t t3,
                                    logic dbl, logic from_one);
    lane_t l;
    l.t[0]     = t0;
    l.t[1]     = t1;
    l.t[2]     = t2;
    l.t[3]     = t3;
    l.dbl      = dbl;
    l.from_one = from_one;
    return l;
  endfunction

  // Quaternion product is left * right in Hamilton order (w,x,y,z = 0..3).
  // Matrix entries use left = right = A.
  function automatic recipe_t recipe(mode_e m);
    recipe_t r;
    term_t   z0;
    z0 = tm(2'd0, 2'd0, SG_ZERO);
    r  = '0;
    case (m)
      MODE_QPROD, MODE_QVEC: begin
        if (m == MODE_QPROD) begin
          r[0] = mk_lane(tm(2'd0, 2'd0, SG_PLUS), tm(2'd1, 2'd1, SG_MINUS),
                         tm(2'd2, 2'd2, SG_MINUS), tm(2'd3, 2'd3, SG_MINUS), 1'b0, 1'b0);
        end
        r[1] = mk_lane(tm(2'd0, 2'd1, SG_PLUS), tm(2'd1, 2'd0, SG_PLUS),
                       tm(2'd2, 2'd3, SG_PLUS), tm(2'd3, 2'd2, SG_MINUS), 1'b0, 1'b0);
        r[2] = mk_lane(tm(2'd0, 2'd2, SG_PLUS), tm(2'd2, 2'd0, SG_PLUS),
                       tm(2'd3, 2'd1, SG_PLUS), tm(2'd1, 2'd3, SG_MINUS), 1'b0, 1'b0);
        r[3] = mk_lane(tm(2'd0, 2'd3, SG_PLUS), tm(2'd1, 2'd2, SG_PLUS),
                       tm(2'd3, 2'd0, SG_PLUS), tm(2'd2, 2'd1, SG_MINUS), 1'b0, 1'b0);
      end
      MODE_MATRIX: begin
        r[0] = mk_lane(tm(2'd2, 2'd2, SG_PLUS), tm(2'd3, 2'd3, SG_PLUS), z0, z0, 1'b1, 1'b1);
        r[1] = mk_lane(tm(2'd1, 2'd2, SG_PLUS), tm(2'd0, 2'd3, SG_MINUS), z0, z0, 1'b1, 1'b0);
        r[2] = mk_lane(tm(2'd1, 2'd3, SG_PLUS), tm(2'd0, 2'd2, SG_PLUS), z0, z0, 1'b1, 1'b0);
        r[3] = mk_lane(tm(2'd1, 2'd2, SG_PLUS), tm(2'd0, 2'd3, SG_PLUS), z0, z0, 1'b1, 1'b0);
        r[4] = mk_lane(tm(2'd1, 2'd1, SG_PLUS), tm(2'd3, 2'd3, SG_PLUS), z0, z0, 1'b1, 1'b1);
        r[5] = mk_lane(tm(2'd2, 2'd3, SG_PLUS), tm(2'd0, 2'd1, SG_MINUS), z0, z0, 1'b1, 1'b0);
        r[6] = mk_lane(tm(2'd1, 2'd3, SG_PLUS), tm(2'd0, 2'd2, SG_MINUS), z0, z0, 1'b1, 1'b0);
        r[7] = mk_lane(tm(2'd2, 2'd3, SG_PLUS), tm(2'd0, 2'd1, SG_PLUS), z0, z0, 1'b1, 1'b0);
        r[8] = mk_lane(tm(2'd1, 2'd1, SG_PLUS), tm(2'd2, 2'd2, SG_PLUS), z0, z0, 1'b1, 1'b1);
      end
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> src/quaternion_arithmetic_unit.sv
// Top level of the quaternion arithmetic unit: multiply, rotate point, rotation matrix, conjugate.
// Depends on qau_pkg and two qau_sop pipelines.

// One request enters per clock while the output is not stalled. The
// path is two three-stage sum-of-products pipelines (products, lane sums,
// round/saturate) in series followed by the output register; the second pipeline
// performs the conjugate product of a rotation, and other actions pass beside it
// unchanged. All values are signed fixed point with FRACTION_BITS fraction bits,
// rounded half up and saturated; overflow reports any saturation on the way. A
// stall on the output freezes the whole pipeline, and the input stall rises only
// when a result is waiting and is not being taken.
module quaternion_arithmetic_unit #(
  parameter int VALUE_WIDTH   = qau_pkg::VALUE_WIDTH_DEF,
  parameter int FRACTION_BITS = qau_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    action_i,
  input  logic signed [VALUE_WIDTH-1:0] a_w_i,
  input  logic signed [VALUE_WIDTH-1:0] a_x_i,
  input  logic signed [VALUE_WIDTH-1:0] a_y_i,
  input  logic signed [VALUE_WIDTH-1:0] a_z_i,
  input  logic signed [VALUE_WIDTH-1:0] b_w_i,
  input  logic signed [VALUE_WIDTH-1:0] b_x_i,
  input  logic signed [VALUE_WIDTH-1:0] b_y_i,
  input  logic signed [VALUE_WIDTH-1:0] b_z_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [VALUE_WIDTH-1:0] r0_o,
  output logic signed [VALUE_WIDTH-1:0] r1_o,
  output logic signed [VALUE_WIDTH-1:0] r2_o,
  output logic signed [VALUE_WIDTH-1:0] r3_o,
  output logic signed [VALUE_WIDTH-1:0] r4_o,
  output logic signed [VALUE_WIDTH-1:0] r5_o,
  output logic signed [VALUE_WIDTH-1:0] r6_o,
  output logic signed [VALUE_WIDTH-1:0] r7_o,
  output logic signed [VALUE_WIDTH-1:0] r8_o,
  output logic                          overflow_o
);

  localparam int DEPTH = 3;
  localparam int QLEN  = qau_pkg::QLEN;
  localparam int LANES = qau_pkg::LANES;
  localparam logic signed [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  logic                          en;
  qau_pkg::action_e              act;
  qau_pkg::mode_e                mode_a;
  logic signed [VALUE_WIDTH-1:0] a_vec    [QLEN];
  logic signed [VALUE_WIDTH-1:0] left_a   [QLEN];
  logic signed [VALUE_WIDTH-1:0] conj_d   [QLEN];
  logic                          cov_d;

  logic                          a_valid, b_valid;
  logic signed [VALUE_WIDTH-1:0] res_a    [LANES];
  logic signed [VALUE_WIDTH-1:0] t_vec    [QLEN];
  logic signed [VALUE_WIDTH-1:0] res_b    [LANES];
  logic                          ovf_a, ovf_b;

  // Side pipeline beside the first product
  logic                          sa_rot_q  [DEPTH];
  logic                          sa_conj_q [DEPTH];
  logic signed [VALUE_WIDTH-1:0] sa_c_q    [DEPTH][QLEN];
  logic                          sa_cov_q  [DEPTH];

  // Side pipeline beside the second product
  logic signed [VALUE_WIDTH-1:0] pre_d     [LANES];
  logic                          pre_ovf_d;
  logic                          sb_rot_q  [DEPTH];
  logic signed [VALUE_WIDTH-1:0] sb_pre_q  [DEPTH][LANES];
  logic                          sb_ovf_q  [DEPTH];

  logic signed [VALUE_WIDTH-1:0] r_d [LANES];
  logic signed [VALUE_WIDTH-1:0] r_q [LANES];
  logic                          ovf_d, ovf_q;
  logic                          out_valid_q;

  // Advance the whole pipeline unless a finished result is held
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  assign act   = qau_pkg::action_e'(action_i);
  assign a_vec = '{a_w_i, a_x_i, a_y_i, a_z_i};

  // Build the conjugate of A, saturating a negated minimum
  always_comb begin
    conj_d[0] = a_w_i;
    cov_d     = 1'b0;
    for (int k = 1; k < QLEN; k++) begin
      if (a_vec[k] == VMIN) begin
        conj_d[k] = VMAX;
        cov_d     = 1'b1;
      end else begin
        conj_d[k] = -a_vec[k];
      end
    end
  end

  // Select the left operand and recipe of the first product
  always_comb begin
    mode_a = qau_pkg::MODE_QPROD;
    case (act)
      qau_pkg::ACT_MAT: begin
        mode_a = qau_pkg::MODE_MATRIX;
        left_a = a_vec;
      end
      qau_pkg::ACT_ROT: begin
        left_a = '{'0, b_x_i, b_y_i, b_z_i};
      end
      default: begin
        left_a = '{b_w_i, b_x_i, b_y_i, b_z_i};
      end
    endcase
  end

  qau_sop #(
    .VALUE_WIDTH  (VALUE_WIDTH),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_sop_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(in_valid_i),
    .mode_i (mode_a),
    .left_i (left_a),
    .right_i(a_vec),
    .valid_o(a_valid),
    .res_o  (res_a),
    .ovf_o  (ovf_a)
  );

  // Carry action flags and conjugate beside the first product
  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_rot_q[0]  <= (act == qau_pkg::ACT_ROT);
      sa_conj_q[0] <= (act == qau_pkg::ACT_CONJ);
      sa_c_q[0]    <= conj_d;
      sa_cov_q[0]  <= cov_d;
      for (int s = 1; s < DEPTH; s++) begin
        sa_rot_q[s]  <= sa_rot_q[s-1];
        sa_conj_q[s] <= sa_conj_q[s-1];
        sa_c_q[s]    <= sa_c_q[s-1];
        sa_cov_q[s]  <= sa_cov_q[s-1];
      end
    end
  end

  // Settle every action except rotate after the first product
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      pre_d[k] = sa_conj_q[DEPTH-1] ? '0 : res_a[k];
    end
    if (sa_conj_q[DEPTH-1]) begin
      for (int k = 0; k < QLEN; k++) begin
        pre_d[k] = sa_c_q[DEPTH-1][k];
      end
    end
    if (sa_conj_q[DEPTH-1]) begin
      pre_ovf_d = sa_cov_q[DEPTH-1];
    end else begin
      pre_ovf_d = ovf_a || (sa_rot_q[DEPTH-1] && sa_cov_q[DEPTH-1]);
    end
  end

  // Take the quaternion lanes of the first product
  always_comb begin
    for (int k = 0; k < QLEN; k++) begin
      t_vec[k] = res_a[k];
    end
  end

  // Second product: conj(A) applied to the rotated intermediate
  qau_sop #(
    .VALUE_WIDTH  (VALUE_WIDTH),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_sop_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(a_valid),
    .mode_i (qau_pkg::MODE_QVEC),
    .left_i (sa_c_q[DEPTH-1]),
    .right_i(t_vec),
    .valid_o(b_valid),
    .res_o  (res_b),
    .ovf_o  (ovf_b)
  );

  // Carry the settled result beside the second product
  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_rot_q[0] <= sa_rot_q[DEPTH-1];
      sb_pre_q[0] <= pre_d;
      sb_ovf_q[0] <= pre_ovf_d;
      for (int s = 1; s < DEPTH; s++) begin
        sb_rot_q[s] <= sb_rot_q[s-1];
        sb_pre_q[s] <= sb_pre_q[s-1];
        sb_ovf_q[s] <= sb_ovf_q[s-1];
      end
    end
  end

  // Pick the rotated point or the settled result
  always_comb begin
    if (sb_rot_q[DEPTH-1]) begin
      for (int k = 0; k < LANES; k++) begin
        r_d[k] = (k >= 1 && k < QLEN) ? res_b[k] : '0;
      end
      ovf_d = sb_ovf_q[DEPTH-1] || ovf_b;
    end else begin
      r_d   = sb_pre_q[DEPTH-1];
      ovf_d = sb_ovf_q[DEPTH-1];
    end
  end

  // Output register: hold the result while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= b_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_q   <= r_d;
      ovf_q <= ovf_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign r0_o        = r_q[0];
  assign r1_o        = r_q[1];
  assign r2_o        = r_q[2];
  assign r3_o        = r_q[3];
  assign r4_o        = r_q[4];
  assign r5_o        = r_q[5];
  assign r6_o        = r_q[6];
  assign r7_o        = r_q[7];
  assign r8_o        = r_q[8];
  assign overflow_o  = ovf_q;

  // Input stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_q && out_stall_i))
    else $error("input stalled without a held result");

  // A frozen pipeline keeps its valid bits
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(a_valid) && $stable(b_valid)))
    else $error("pipeline valid changed while frozen");

  // Taking the last result with nothing behind it empties the output
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && !b_valid) |=> !out_valid_q)
    else $error("result repeated after it was taken");

endmodule

>>> src/qau_sop.sv
// Three-stage sum-of-products pipeline: 16 products, nine lane sums, round and saturate.
// Depends on qau_pkg for lane recipes and sizes.
module qau_sop #(
  parameter int VALUE_WIDTH   = qau_pkg::VALUE_WIDTH_DEF,
  parameter int FRACTION_BITS = qau_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  qau_pkg::mode_e                mode_i,
  input  logic signed [VALUE_WIDTH-1:0] left_i  [qau_pkg::QLEN],
  input  logic signed [VALUE_WIDTH-1:0] right_i [qau_pkg::QLEN],
  output logic                          valid_o,
  output logic signed [VALUE_WIDTH-1:0] res_o   [qau_pkg::LANES],
  output logic                          ovf_o
);

  localparam int PW = 2 * VALUE_WIDTH;
  localparam int AW = ((PW > 2 * FRACTION_BITS) ? PW : 2 * FRACTION_BITS) + 3;
  localparam int NP = qau_pkg::QLEN * qau_pkg::QLEN;

  localparam logic signed [AW-1:0] ONE  = {{(AW-1){1'b0}}, 1'b1} << (2 * FRACTION_BITS);
  localparam logic signed [AW-1:0] HALF = {{(AW-1){1'b0}}, 1'b1} << (FRACTION_BITS - 1);
  localparam logic signed [AW-1:0] ONE_HALF = ONE + HALF;
  localparam logic signed [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  logic                          v1_q, v2_q, v3_q;
  qau_pkg::mode_e                mode1_q, mode2_q;
  logic signed [PW-1:0]          prod_d [NP];
  logic signed [PW-1:0]          prod_q [NP];
  logic signed [AW-1:0]          acc_d  [qau_pkg::LANES];
  logic signed [AW-1:0]          acc_q  [qau_pkg::LANES];
  logic signed [VALUE_WIDTH-1:0] res_d  [qau_pkg::LANES];
  logic signed [VALUE_WIDTH-1:0] res_q  [qau_pkg::LANES];
  logic                          ovf_d, ovf_q;

  // Advance valid bits with the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage 1: form every left by right product
  always_comb begin
    for (int i = 0; i < qau_pkg::QLEN; i++) begin
      for (int j = 0; j < qau_pkg::QLEN; j++) begin
        prod_d[i*qau_pkg::QLEN+j] = PW'(left_i[i]) * PW'(right_i[j]);
      end
    end
  end

  // Stage 2: add the selected products per lane at full precision
  always_comb begin
    qau_pkg::recipe_t     rc;
    qau_pkg::term_t       t;
    logic signed [PW-1:0] p;
    logic signed [AW-1:0] ext;
    logic signed [AW-1:0] sum;
    rc = qau_pkg::recipe(mode1_q);
    for (int k = 0; k < qau_pkg::LANES; k++) begin
      sum = '0;
      for (int n = 0; n < qau_pkg::TERMS; n++) begin
        t   = rc[k].t[n];
        p   = prod_q[{t.li, t.ri}];
        ext = {{(AW-PW){p[PW-1]}}, p};
        case (t.sg)
          qau_pkg::SG_PLUS:  sum = sum + ext;
          qau_pkg::SG_MINUS: sum = sum - ext;
          default:           sum = sum;
        endcase
      end
      if (rc[k].dbl) begin
        sum = sum <<< 1;
      end
      acc_d[k] = sum;
    end
  end

  // Stage 3: subtract from one where asked, round half up, shift, saturate
  always_comb begin
    qau_pkg::recipe_t                rc;
    logic signed [AW-1:0]            rnd;
    logic signed [AW-1:0]            shf;
    logic        [AW-VALUE_WIDTH:0]  hi;
    rc    = qau_pkg::recipe(mode2_q);
    ovf_d = 1'b0;
    for (int k = 0; k < qau_pkg::LANES; k++) begin
      rnd = rc[k].from_one ? (ONE_HALF - acc_q[k]) : (acc_q[k] + HALF);
      shf = rnd >>> FRACTION_BITS;
      hi  = shf[AW-1:VALUE_WIDTH-1];
      if ((&hi) || !(|hi)) begin
        res_d[k] = shf[VALUE_WIDTH-1:0];
      end else begin
        res_d[k] = shf[AW-1] ? VMIN : VMAX;
        ovf_d    = 1'b1;
      end
    end
  end

  // Hold payload while stalled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mode1_q <= mode_i;
      mode2_q <= mode1_q;
      prod_q  <= prod_d;
      acc_q   <= acc_d;
      res_q   <= res_d;
      ovf_q   <= ovf_d;
    end
  end

  assign valid_o = v3_q;
  assign res_o   = res_q;
  assign ovf_o   = ovf_q;

endmodule

>>> tb/sv/quaternion_arithmetic_unit_test.sv
// Self-checking testbench for quaternion_arithmetic_unit: multiply, rotate, matrix, conjugate.
// Depends on qau_pkg and the quaternion_arithmetic_unit RTL; predicts every result in Q2.14.
module quaternion_arithmetic_unit_test;

  localparam int VW = qau_pkg::VALUE_WIDTH_DEF;
  localparam int FB = qau_pkg::FRACTION_BITS_DEF;
  localparam longint VMAX = (longint'(1) <<< (VW - 1)) - 1;
  localparam longint VMIN = -(longint'(1) <<< (VW - 1));
  localparam longint ONE = longint'(1) <<< FB;
  localparam int RANDOM_REQS = 1030;
  localparam int HOLD_AT = 150;
  localparam int HOLD_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    qau_pkg::action_e act;
    logic signed [VW-1:0] a [4];
    logic signed [VW-1:0] b [4];
  } quat_req_t;

  typedef struct {
    logic signed [VW-1:0] r [9];
    logic ovf;
  } quat_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] action_i = qau_pkg::ACT_MUL;
  logic signed [VW-1:0] a_w_i = '0, a_x_i = '0, a_y_i = '0, a_z_i = '0;
  logic signed [VW-1:0] b_w_i = '0, b_x_i = '0, b_y_i = '0, b_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [VW-1:0] r0_o, r1_o, r2_o, r3_o, r4_o, r5_o, r6_o, r7_o, r8_o;
  logic overflow_o;

  quat_req_t quat_reqs_todo [$];
  quat_res_t predicted_results [$];
  int mismatches = 0;
  int results_seen = 0;
  logic wind_down = 1'b0;

  quaternion_arithmetic_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .a_w_i      (a_w_i),
    .a_x_i      (a_x_i),
    .a_y_i      (a_y_i),
    .a_z_i      (a_z_i),
    .b_w_i      (b_w_i),
    .b_x_i      (b_x_i),
    .b_y_i      (b_y_i),
    .b_z_i      (b_z_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .r0_o       (r0_o),
    .r1_o       (r1_o),
    .r2_o       (r2_o),
    .r3_o       (r3_o),
    .r4_o       (r4_o),
    .r5_o       (r5_o),
    .r6_o       (r6_o),
    .r7_o       (r7_o),
    .r8_o       (r8_o),
    .overflow_o (overflow_o)
  );

  always #5 clk_i = ~clk_i;

  // Round half up, drop the fraction bits, clamp to the value range
  function automatic longint round_sat(longint s, inout bit ovf);
    longint q;
    q = (s + (longint'(1) <<< (FB - 1))) >>> FB;
    if (q > VMAX) begin
      ovf = 1'b1;
      return VMAX;
    end
    if (q < VMIN) begin
      ovf = 1'b1;
      return VMIN;
    end
    return q;
  endfunction

  function automatic longint neg_sat(longint v, inout bit ovf);
    if (v == VMIN) begin
      ovf = 1'b1;
      return VMAX;
    end
    return -v;
  endfunction

  // Product of l and r taken as the Hamilton product r*l
  function automatic void hamilton_prod(input longint l [4], input longint r [4],
                                        input bit want_w, inout bit ovf,
                                        output longint o [4]);
    if (want_w)
      o[0] = round_sat(r[0]*l[0] - r[1]*l[1] - r[2]*l[2] - r[3]*l[3], ovf);
    else
      o[0] = 0;
    o[1] = round_sat(r[0]*l[1] + r[1]*l[0] + r[2]*l[3] - r[3]*l[2], ovf);
    o[2] = round_sat(r[0]*l[2] + r[2]*l[0] + r[3]*l[1] - r[1]*l[3], ovf);
    o[3] = round_sat(r[0]*l[3] + r[1]*l[2] + r[3]*l[0] - r[2]*l[1], ovf);
  endfunction

  // Doubled two-term sum, optionally taken from one, for a matrix entry
  function automatic longint matrix_entry(longint p0, longint q0, int s1, longint p1,
                                          longint q1, bit from_one, inout bit ovf);
    longint s;
    s = 2 * (p0 * q0 + s1 * p1 * q1);
    if (from_one)
      s = (ONE * ONE) - s;
    return round_sat(s, ovf);
  endfunction

  function automatic quat_res_t quat_predict(quat_req_t q);
    quat_res_t res;
    longint a [4], b [4], pt [4], t [4], c [4], u [4];
    bit ovf;
    ovf = 1'b0;
    for (int i = 0; i < 4; i++) begin
      a[i] = longint'(q.a[i]);
      b[i] = longint'(q.b[i]);
      u[i] = 0;
    end
    for (int i = 0; i < 9; i++)
      res.r[i] = '0;
    case (q.act)
      qau_pkg::ACT_MUL: begin
        hamilton_prod(a, b, 1'b1, ovf, u);
        for (int i = 0; i < 4; i++)
          res.r[i] = VW'(u[i]);
      end
      qau_pkg::ACT_ROT: begin
        pt = '{0, b[1], b[2], b[3]};
        hamilton_prod(a, pt, 1'b1, ovf, t);
        c[0] = a[0];
        for (int i = 1; i < 4; i++)
          c[i] = neg_sat(a[i], ovf);
        hamilton_prod(t, c, 1'b0, ovf, u);
        for (int i = 1; i < 4; i++)
          res.r[i] = VW'(u[i]);
      end
      qau_pkg::ACT_MAT: begin
        res.r[0] = VW'(matrix_entry(a[2], a[2], 1, a[3], a[3], 1'b1, ovf));
        res.r[1] = VW'(matrix_entry(a[1], a[2], -1, a[0], a[3], 1'b0, ovf));
        res.r[2] = VW'(matrix_entry(a[1], a[3], 1, a[0], a[2], 1'b0, ovf));
        res.r[3] = VW'(matrix_entry(a[1], a[2], 1, a[0], a[3], 1'b0, ovf));
        res.r[4] = VW'(matrix_entry(a[1], a[1], 1, a[3], a[3], 1'b1, ovf));
        res.r[5] = VW'(matrix_entry(a[2], a[3], -1, a[0], a[1], 1'b0, ovf));
        res.r[6] = VW'(matrix_entry(a[1], a[3], -1, a[0], a[2], 1'b0, ovf));
        res.r[7] = VW'(matrix_entry(a[2], a[3], 1, a[0], a[1], 1'b0, ovf));
        res.r[8] = VW'(matrix_entry(a[1], a[1], 1, a[2], a[2], 1'b1, ovf));
      end
      default: begin
        res.r[0] = q.a[0];
        for (int i = 1; i < 4; i++)
          res.r[i] = VW'(neg_sat(a[i], ovf));
      end
    endcase
    res.ovf = ovf;
    return res;
  endfunction

  task automatic add_req(qau_pkg::action_e act, int aw, int ax, int ay, int az,
                         int bw, int bx, int by, int bz);
    quat_req_t q;
    q.act = act;
    q.a = '{VW'(aw), VW'(ax), VW'(ay), VW'(az)};
    q.b = '{VW'(bw), VW'(bx), VW'(by), VW'(bz)};
    quat_reqs_todo.push_back(q);
  endtask

  // Mostly unit-scale values, some full range, some tiny ones to hit rounding
  function automatic int rand_component(int kind);
    case (kind)
      0: return int'($urandom_range(0, 65535)) - 32768;
      1: return int'($urandom_range(0, 128)) - 64;
      default: return int'($urandom_range(0, 32768)) - 16384;
    endcase
  endfunction

  // Offer requests from the queue, with random idle bursts between them
  always @(posedge clk_i or negedge rst_ni) begin : drive_blk
    quat_req_t cur_req;
    int send_gap;
    int send_idle_pct;
    logic offer;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
      send_idle_pct = 20;
    end else begin
      offer = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        predicted_results.push_back(quat_predict(cur_req));
        offer = 1'b0;
      end
      if ($urandom_range(255) == 0) begin
        case ($urandom_range(3))
          0: send_idle_pct = 0;
          1: send_idle_pct = 10;
          2: send_idle_pct = 30;
          default: send_idle_pct = 60;
        endcase
      end
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (!wind_down && $urandom_range(99) < send_idle_pct) begin
          send_gap = $urandom_range(1, 9) - 1;
        end else if (quat_reqs_todo.size() > 0) begin
          cur_req = quat_reqs_todo.pop_front();
          offer = 1'b1;
          action_i <= cur_req.act;
          a_w_i <= cur_req.a[0];
          a_x_i <= cur_req.a[1];
          a_y_i <= cur_req.a[2];
          a_z_i <= cur_req.a[3];
          b_w_i <= cur_req.b[0];
          b_x_i <= cur_req.b[1];
          b_y_i <= cur_req.b[2];
          b_z_i <= cur_req.b[3];
        end
      end
      in_valid_i <= offer;
      wind_down <= (quat_reqs_todo.size() < 60);
    end
  end

  // Check each accepted result, then decide whether to stall the next cycle
  always @(posedge clk_i or negedge rst_ni) begin : recv_blk
    quat_res_t want;
    logic signed [VW-1:0] got [9];
    int recv_gap;
    int recv_idle_pct;
    int hold_left;
    bit hold_done;
    logic stall;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      recv_gap = 0;
      recv_idle_pct = 20;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      got = '{r0_o, r1_o, r2_o, r3_o, r4_o, r5_o, r6_o, r7_o, r8_o};
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (predicted_results.size() == 0) begin
          $error("result arrived with no request outstanding");
          mismatches++;
        end else begin
          want = predicted_results.pop_front();
          for (int i = 0; i < 9; i++) begin
            if (got[i] !== want.r[i]) begin
              $error("r%0d: expected %0d, actual %0d", i, want.r[i], got[i]);
              mismatches++;
            end
          end
          if (overflow_o !== want.ovf) begin
            $error("overflow: expected %0d, actual %0d", want.ovf, overflow_o);
            mismatches++;
          end
        end
      end
      if ($urandom_range(255) == 0) begin
        case ($urandom_range(3))
          0: recv_idle_pct = 0;
          1: recv_idle_pct = 10;
          2: recv_idle_pct = 30;
          default: recv_idle_pct = 60;
        endcase
      end
      // Hold off once for a long stretch so the pipeline fills and backs up
      if (hold_left > 0) begin
        hold_left--;
        stall = 1'b1;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        stall = 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        stall = 1'b1;
      end else if (!wind_down && $urandom_range(99) < recv_idle_pct) begin
        recv_gap = $urandom_range(1, 9) - 1;
        stall = 1'b1;
      end else begin
        stall = 1'b0;
      end
      out_stall_i <= stall;
    end
  end

  // End the run if nothing moves on either side for too long
  always @(posedge clk_i) begin : watchdog_blk
    int quiet_cycles;
    if (!rst_ni) begin
      quiet_cycles = 0;
    end else begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL quaternion_arithmetic_unit");
        $finish;
      end
    end
  end

  initial begin : stim_blk
    int kind;
    // Identities, extremes, rounding ties
    add_req(qau_pkg::ACT_MUL, 16384, 0, 0, 0, 16384, 0, 0, 0);
    add_req(qau_pkg::ACT_MUL, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    add_req(qau_pkg::ACT_MUL, -32768, -32768, -32768, -32768,
            -32768, -32768, -32768, -32768);
    add_req(qau_pkg::ACT_MUL, 32767, -32768, 32767, -32768, -32768, 32767, -32768, 32767);
    add_req(qau_pkg::ACT_MUL, 1, 0, 0, 0, 8192, 0, 0, 0);
    add_req(qau_pkg::ACT_MUL, 1, 0, 0, 0, -8192, 0, 0, 0);
    add_req(qau_pkg::ACT_MUL, 0, 0, 0, 0, 0, 0, 0, 0);
    // Rotation: identity, conjugate of the most negative part, extremes, quarter turn
    add_req(qau_pkg::ACT_ROT, 16384, 0, 0, 0, 0, 16384, -16384, 8192);
    add_req(qau_pkg::ACT_ROT, 16384, -32768, 0, 0, 0, 16384, 16384, 16384);
    add_req(qau_pkg::ACT_ROT, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    add_req(qau_pkg::ACT_ROT, -32768, -32768, -32768, -32768, 1234, -32768, -32768, -32768);
    add_req(qau_pkg::ACT_ROT, 11585, 0, 0, 11585, -32768, 16384, 0, 0);
    // Matrix: identity, non-unit extremes, zero quaternion, quarter turn
    add_req(qau_pkg::ACT_MAT, 16384, 0, 0, 0, 0, 0, 0, 0);
    add_req(qau_pkg::ACT_MAT, 32767, 32767, 32767, 32767, 0, 0, 0, 0);
    add_req(qau_pkg::ACT_MAT, -32768, -32768, -32768, -32768, 0, 0, 0, 0);
    add_req(qau_pkg::ACT_MAT, 0, 0, 0, 0, 32767, -32768, 32767, -32768);
    add_req(qau_pkg::ACT_MAT, 11585, 11585, 0, 0, 0, 0, 0, 0);
    // Conjugate: most negative parts saturate, scalar passes untouched
    add_req(qau_pkg::ACT_CONJ, -32768, -32768, -32768, -32768, 0, 0, 0, 0);
    add_req(qau_pkg::ACT_CONJ, 32767, 32767, 32767, 32767, -1, -1, -1, -1);
    add_req(qau_pkg::ACT_CONJ, 0, 0, 0, 0, 0, 0, 0, 0);
    add_req(qau_pkg::ACT_CONJ, -32768, 1, -1, 32767, 0, 0, 0, 0);
    // Random requests with a mix of value scales
    for (int k = 0; k < RANDOM_REQS; k++) begin
      kind = $urandom_range(99);
      kind = (kind < 15) ? 0 : (kind < 30) ? 1 : 2;
      add_req(qau_pkg::action_e'($urandom_range(3)),
              rand_component(kind), rand_component(kind),
              rand_component(kind), rand_component(kind),
              rand_component(kind), rand_component(kind),
              rand_component(kind), rand_component(kind));
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Drain: all requests accepted, all results back, then a short settle
    while (quat_reqs_todo.size() != 0 || in_valid_i)
      @(posedge clk_i);
    while (predicted_results.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS quaternion_arithmetic_unit");
    end else begin
      $display("FAIL quaternion_arithmetic_unit");
    end
    $finish;
  end

endmodule
